// File: rtl/core/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none
package hbp_pkg;

    localparam int FUNC_W = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    localparam logic [BYTE_W-1:0] MARK_PARTIAL = 8'd127;
    localparam logic [BYTE_W-1:0] MARK_ALIGNED = 8'd126;

    // One table entry: codeword and its length.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hbp_entry_t;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic       finish;
        hbp_entry_t entry;
    } hbp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/huffman_bit_packer_core.sv
// Huffman bit packer top level. An accepted encode passes the front-end lookup register,
// the command queue and the back-end accumulator before it reaches the output register.
// While a codeword drains, the back end emits one byte per cycle unless the output stalls;
// it takes no new command until the codeword has drained. A finish emits a trailer of two
// or three bytes. Synchronous active-low reset clears the stream state and the queue; the
// code table is not reset. Depends on hbp_pkg, hbp_front, hbp_queue and hbp_back.
`default_nettype none
module huffman_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);
    import hbp_pkg::*;

    logic     push_valid;
    logic     push_ready;
    hbp_cmd_t push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    hbp_cmd_t pop_cmd;

    hbp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_func       (s_axis_tuser),
        .in_symbol     (s_axis_tdata[7:0]),
        .in_code_bits  (s_axis_tdata[39:8]),
        .in_code_length(s_axis_tdata[45:40]),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    hbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd)
    );

    hbp_back #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(pop_valid),
        .cmd_ready(pop_ready),
        .cmd      (pop_cmd),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_byte (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/core/hbp_front.sv
// Front end: accepts input words, keeps the code table and looks up codewords.
// Depends on hbp_pkg.
`default_nettype none
module hbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [hbp_pkg::FUNC_W-1:0]   in_func,
    input  wire logic [hbp_pkg::SYM_W-1:0]    in_symbol,
    input  wire logic [hbp_pkg::CODE_W-1:0]   in_code_bits,
    input  wire logic [hbp_pkg::LEN_W-1:0]    in_code_length,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output hbp_pkg::hbp_cmd_t                 push_cmd
);
    import hbp_pkg::*;

    localparam int IDX_W = $clog2(NUM_SYMBOLS);

    hbp_entry_t table_mem [NUM_SYMBOLS];

    logic       st_valid_reg;
    logic       st_finish_reg;
    hbp_entry_t rd_reg;

    logic             accept;
    logic             in_range;
    logic             push_req;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len_sat;
    hbp_entry_t       wr_entry;

    assign idx      = in_symbol[IDX_W-1:0];
    assign in_range = ({1'b0, in_symbol} < (SYM_W+1)'(NUM_SYMBOLS));
    assign len_sat  = (in_code_length > LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : in_code_length;
    assign wr_entry = '{code: in_code_bits, len: len_sat};

    // Encodes whose entry has zero length leave the stage without a push.
    assign push_req   = st_valid_reg && (st_finish_reg || (rd_reg.len != '0));
    assign push_valid = push_req;
    assign push_cmd   = '{finish: st_finish_reg, entry: rd_reg};
    assign in_ready   = !st_valid_reg || !push_req || push_ready;
    assign accept     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (accept && (in_func == FUNC_LOAD) && in_range) begin
            table_mem[idx] <= wr_entry;
        end
        if (accept && (in_func == FUNC_ENCODE)) begin
            rd_reg <= table_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            st_finish_reg <= 1'b0;
        end else if (in_ready) begin
            st_valid_reg  <= in_valid && (((in_func == FUNC_ENCODE) && in_range) ||
                                          (in_func == FUNC_FINISH));
            st_finish_reg <= (in_func == FUNC_FINISH);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/hbp_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on hbp_pkg.
`default_nettype none
module hbp_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  hbp_pkg::hbp_cmd_t push_cmd,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output hbp_pkg::hbp_cmd_t pop_cmd
);
    import hbp_pkg::*;

    hbp_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/hbp_back.sv
// Back end: bit accumulator, byte emitter, stream trailer and output register.
// Depends on hbp_pkg.
`default_nettype none
module hbp_back #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  hbp_pkg::hbp_cmd_t               cmd,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [hbp_pkg::BYTE_W-1:0]      out_byte,
    output logic                            out_last
);
    import hbp_pkg::*;

    localparam int ACC_W = 7 + MAX_CODE_LEN;
    localparam int TOT_W = $clog2(ACC_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_FIN
    } state_t;

    state_t             state_reg,     state_next;
    logic [ACC_W-1:0]   acc_reg,       acc_next;
    logic [TOT_W-1:0]   total_reg,     total_next;
    logic [6:0]         pend_bits_reg, pend_bits_next;
    logic [2:0]         pend_cnt_reg,  pend_cnt_next;
    logic               emitted_reg,   emitted_next;
    logic               fin_long_reg,  fin_long_next;
    logic [1:0]         fin_idx_reg,   fin_idx_next;
    logic               m_valid_reg,   m_valid_next;
    logic [BYTE_W-1:0]  m_data_reg,    m_data_next;
    logic               m_last_reg,    m_last_next;

    logic               out_free;
    logic [ACC_W-1:0]   acc_load;
    logic [TOT_W-1:0]   total_load;
    logic [TOT_W-1:0]   remain;
    logic [ACC_W-1:0]   remain_mask;
    logic [ACC_W-1:0]   code_mask;

    assign out_free  = !m_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = m_valid_reg;
    assign out_byte  = m_data_reg;
    assign out_last  = m_last_reg;

    // New codeword appended below the pending bits.
    assign code_mask  = (ACC_W'(1) << cmd.entry.len) - ACC_W'(1);
    assign acc_load   = (ACC_W'(pend_bits_reg) << cmd.entry.len) |
                        (ACC_W'(cmd.entry.code) & code_mask);
    assign total_load = TOT_W'(pend_cnt_reg) + TOT_W'(cmd.entry.len);

    assign remain      = total_reg - TOT_W'(8);
    assign remain_mask = (ACC_W'(1) << remain) - ACC_W'(1);

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        emitted_next   = emitted_reg;
        fin_long_next  = fin_long_reg;
        fin_idx_next   = fin_idx_reg;
        m_valid_next   = m_valid_reg && !out_ready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.finish) begin
                        fin_long_next = (pend_cnt_reg != 3'd0) || !emitted_reg;
                        fin_idx_next  = 2'd0;
                        state_next    = ST_FIN;
                    end else if (total_load < TOT_W'(8)) begin
                        pend_bits_next = 7'(acc_load);
                        pend_cnt_next  = 3'(total_load);
                    end else begin
                        acc_next   = acc_load;
                        total_next = total_load;
                        state_next = ST_ENC;
                    end
                end
            end
            ST_ENC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = BYTE_W'(acc_reg >> remain);
                    m_last_next  = (remain < TOT_W'(8));
                    total_next   = remain;
                    if (remain < TOT_W'(8)) begin
                        pend_bits_next = 7'(acc_reg & remain_mask);
                        pend_cnt_next  = 3'(remain);
                        emitted_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b0;
                    fin_idx_next = fin_idx_reg + 2'd1;
                    case (fin_idx_reg)
                        2'd0: m_data_next = fin_long_reg ? {1'b0, pend_bits_reg} : '0;
                        2'd1: begin
                            if (fin_long_reg) begin
                                m_data_next = BYTE_W'(pend_cnt_reg);
                            end else begin
                                m_data_next = MARK_ALIGNED;
                                m_last_next = 1'b1;
                            end
                        end
                        default: begin
                            m_data_next = MARK_PARTIAL;
                            m_last_next = 1'b1;
                        end
                    endcase
                    if (m_last_next) begin
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                        emitted_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            emitted_reg   <= 1'b0;
            fin_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            emitted_reg   <= emitted_next;
            fin_idx_reg   <= fin_idx_next;
            m_valid_reg   <= m_valid_next;
        end
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        fin_long_reg <= fin_long_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule
`default_nettype wire

// File: test/tb_huffman_bit_packer_core.sv
// Self-checking testbench for huffman_bit_packer_core: a table of directed words,
// then random load, encode, flush and ignored-func traffic with bursty input and a stalling output.
// Depends on hbp_pkg and the huffman_bit_packer_core RTL.
module tb_huffman_bit_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int MAX_LEN        = 32;
    localparam int RAND_ITEMS     = 375;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DIR_ROWS       = 25;

    // One directed word; when typed is set, the listed bytes are the expected
    // output, first byte in the lowest bits and tlast on the final one.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              typed;
        logic [2:0]        n_typed;
        logic [31:0]       bytes;
    } dir_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    huffman_bit_packer_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state: code table plus the partial-byte accumulator.
    logic [CODE_W-1:0] code_tbl [256];
    logic [LEN_W-1:0]  len_tbl [256];
    logic [6:0]        pend_bits;
    logic [2:0]        pend_cnt;
    logic              byte_sent;

    out_word_t  expected_words [$];
    logic       sym_loaded [256];
    logic [7:0] loaded_syms [$];
    dir_row_t   dir_tbl [DIR_ROWS];

    int burst_left    = 0;
    int stall_left    = 0;
    int cyc           = 0;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int n_loads       = 0;
    int n_encodes     = 0;
    int n_flushes     = 0;
    int n_ignored     = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Returns the number of bytes the word produces and packs them into bytes_o.
    function automatic int packer_predict(input logic [FUNC_W-1:0] fn,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [CODE_W-1:0] code,
                                          input logic [LEN_W-1:0] len,
                                          output logic [31:0] bytes_o);
        logic [63:0] acc;
        int          total;
        int          blen;
        int          nb;
        bytes_o = '0;
        nb = 0;
        case (fn)
            FUNC_LOAD: begin
                code_tbl[sym] = code;
                len_tbl[sym]  = (int'(len) > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
            end
            FUNC_ENCODE: begin
                blen = int'(len_tbl[sym]);
                if (blen != 0) begin
                    acc = ({57'd0, pend_bits} << blen)
                        | ({32'd0, code_tbl[sym]} & ((64'd1 << blen) - 64'd1));
                    total = int'(pend_cnt) + blen;
                    while (total >= 8) begin
                        total -= 8;
                        bytes_o[nb*8 +: 8] = 8'(acc >> total);
                        nb++;
                    end
                    if (nb > 0) byte_sent = 1'b1;
                    pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                    pend_cnt  = 3'(total);
                end
            end
            FUNC_FINISH: begin
                if (pend_cnt != 3'd0 || !byte_sent) begin
                    bytes_o = {8'd0, MARK_PARTIAL, 5'd0, pend_cnt, 1'b0, pend_bits};
                    nb = 3;
                end else begin
                    bytes_o = {16'd0, MARK_ALIGNED, 8'd0};
                    nb = 2;
                end
                pend_bits = '0;
                pend_cnt  = '0;
                byte_sent = 1'b0;
            end
            default: ;
        endcase
        return nb;
    endfunction

    // Drives one word through the input handshake, honoring the burst/gap pattern,
    // and queues the bytes it should produce once it is accepted.
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input logic use_typed, input logic [2:0] n_typed,
                             input logic [31:0] typed_bytes);
        int          gap;
        int          npred;
        logic [31:0] pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, len, code, sym};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);

        npred = packer_predict(fn, sym, code, len, pred);
        if (use_typed) begin
            npred = int'(n_typed);
            pred  = typed_bytes;
        end
        for (int i = 0; i < npred; i++)
            expected_words.push_back('{data: pred[i*8 +: 8], last: (i == npred - 1)});

        case (fn)
            FUNC_LOAD: begin
                n_loads++;
                if (!sym_loaded[sym]) begin
                    sym_loaded[sym] = 1'b1;
                    loaded_syms.push_back(sym);
                end
            end
            FUNC_ENCODE: n_encodes++;
            FUNC_FINISH: n_flushes++;
            default:     n_ignored++;
        endcase
    endtask

    // Receiver: random stalls in three of every four windows, full-rate windows in between.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (cyc[9:8] != 2'd0 && $urandom_range(0, 99) < 25) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Output checker and watchdog.
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                $error("out_byte: expected nothing, got %0h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_w = expected_words.pop_front();
                if (m_axis_tdata !== exp_w.data) begin
                    $error("out_byte: expected %0h, got %0h", exp_w.data, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== exp_w.last) begin
                    $error("last: expected %0b, got %0b", exp_w.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
        int          pick;
        int          items_sent;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        aresetn       <= 1'b0;
        pend_bits = '0;
        pend_cnt  = '0;
        byte_sent = 1'b0;
        for (int i = 0; i < 256; i++) sym_loaded[i] = 1'b0;

        // Directed words: empty-stream flush, ignored func, saturated and zero
        // lengths, stray high code bits, leftover and aligned flushes, 32-bit codes.
        dir_tbl = '{
            '{FUNC_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd3, 32'h007F_0000},
            '{FUNC_UNUSED, 8'hA5, 32'hDEAD_BEEF, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd3, 32'h007F_0000},
            '{FUNC_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd8,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_LOAD,   8'hFF, 32'hAAAA_AAAA, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd1,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_LOAD,   8'h02, 32'h1234_5678, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_LOAD,   8'h03, 32'hFFFF_FFFD, 6'd3,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_00FF},
            '{FUNC_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd2, 32'h0000_7E00},
            '{FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd3, 32'h007F_0101},
            '{FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hAAAA_AAAA},
            '{FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'hFF, 32'h5555_5555, 6'd21, 1'b0, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{FUNC_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{FUNC_LOAD,   8'h80, 32'h0000_0000, 6'd32, 1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'h0000_0000},
            '{FUNC_LOAD,   8'h7F, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
            '{FUNC_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd2, 32'h0000_7E00},
            '{FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i])
            send_word(dir_tbl[i].func, dir_tbl[i].sym, dir_tbl[i].code, dir_tbl[i].len,
                      dir_tbl[i].typed, dir_tbl[i].n_typed, dir_tbl[i].bytes);

        // Random traffic: mostly encodes of loaded symbols, with table rewrites,
        // flushes at random points and a little ignored-func noise.
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            sym  = 8'($urandom_range(0, 255));
            code = $urandom;
            len  = 6'($urandom_range(0, 63));
            if (items_sent < 16 || pick < 12) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 6'd0;
                else if (pick < 70)
                    len = 6'($urandom_range(1, 10));
                else if (pick < 90)
                    len = 6'($urandom_range(11, 32));
                else
                    len = 6'($urandom_range(33, 63));
                send_word(FUNC_LOAD, sym, code, len, 1'b0, 3'd0, 32'd0);
                items_sent++;
            end else if (pick < 88) begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                send_word(FUNC_ENCODE, sym, code, len, 1'b0, 3'd0, 32'd0);
                items_sent++;
            end else if (pick < 97) begin
                send_word(FUNC_FINISH, sym, code, len, 1'b0, 3'd0, 32'd0);
                items_sent++;
            end else begin
                send_word(FUNC_UNUSED, sym, code, len, 1'b0, 3'd0, 32'd0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d loads, %0d encodes, %0d flushes and %0d ignored words.",
                 n_loads, n_encodes, n_flushes, n_ignored);
        $display("Checked %0d output bytes, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
